// ----- src/wasa_pkg.sv -----
// Shared constants, types and helper functions of the weighted assignment solver.
`timescale 1ns / 1ps
package wasa_pkg;

   // Problem size and cost format.
   localparam int MAX_ROWS  = 16;
   localparam int MAX_COLS  = 16;
   localparam int COST_BITS = 16;

   // Derived widths.
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int CNT_W    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
   localparam int OWN_W    = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int POT_W    = 22;
   localparam int SLK_W    = POT_W + 2;
   localparam int ROUND_LIMIT = MAX_COLS + 1;
   localparam int RND_W    = $clog2(ROUND_LIMIT + 1);

   // Field widths of the channels.
   localparam int IDX_W      = 4;
   localparam int ENTRY_W    = 16;
   localparam int TOT_W      = 20;
   localparam int MEAN_W     = 16;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int DIV_CNT_W  = $clog2(TOT_W + 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = CSR_IDX_W'(1);

   // Request to the divider.
   typedef struct packed {
      logic               start;
      logic [TOT_W-1:0]   dividend;
      logic [CNT_W-1:0]   divisor;
   } div_req_type;

   // Response of the divider.
   typedef struct packed {
      logic               done;
      logic [MEAN_W-1:0]  quotient;
   } div_rsp_type;

   // A count of zero reads as one, a count above the maximum saturates.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxv);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CNT_W'(v) > maxv) begin
         r = maxv;
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

// ----- src/wasa_if.sv -----
// Channel interfaces of the solver: cost entries, results and register writes.
`timescale 1ns / 1ps
interface wasa_req_if import wasa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   row_index;
   logic [IDX_W-1:0]   col_index;
   logic [ENTRY_W-1:0] entry_cost;
   logic               last_entry;
   modport source (output valid, row_index, col_index, entry_cost, last_entry, input ready);
   modport sink   (input valid, row_index, col_index, entry_cost, last_entry, output ready);
endinterface

interface wasa_rsp_if import wasa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  column;
   logic [IDX_W-1:0]  assigned_row;
   logic              matched;
   logic [TOT_W-1:0]  total_cost;
   logic [MEAN_W-1:0] mean_cost;
   logic              last_result;
   modport source (output valid, column, assigned_row, matched, total_cost, mean_cost,
                   last_result, input ready);
   modport sink   (input valid, column, assigned_row, matched, total_cost, mean_cost,
                   last_result, output ready);
endinterface

interface wasa_csr_if import wasa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/wasa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module wasa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wasa_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the mean cost.
`timescale 1ns / 1ps
module wasa_divider import wasa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [TOT_W-1:0]     quo_ff, quo_in;
   logic [CNT_W:0]       shifted;

   // The dividend shifts out at the top while quotient bits shift in below.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[TOT_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(TOT_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_req.divisor}) begin
            rem_in = CNT_W'(shifted - {1'b0, div_req.divisor});
            quo_in = {quo_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(shifted);
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[MEAN_W-1:0];

endmodule

// ----- src/weighted_assignment_solver_core.sv -----
// Top level: cost memory, labelling sequencer and result channel of the solver.
`timescale 1ns / 1ps
// Minimum-cost assignment of rows to columns (Kuhn-Munkres labelling method).
// The req_bus channel takes one cost entry per transaction, one per cycle while
// the block is idle, and writes it into the cost memory. A transaction with
// last_entry set also starts the solve; req_bus.ready stays low until all
// results have been delivered. The solve reads the cost memory once per step
// (one state to address, one to evaluate) in the row-minimum pass, the search
// steps and each label update, a slack sweep over all rows and columns; each
// row takes at most 18 search rounds. The total then follows, and the mean
// comes from the bit-serial divider.
// One result transaction per column follows on rsp_bus, in column order,
// one per cycle while the receiver is ready; a stall simply holds the current
// result. The csr_bus channel writes num_rows and num_cols and is always
// ready; it is to be used only while the block is idle, which the block
// itself does not enforce. Reset returns the sequencer to idle and both counts
// to 16; the cost memory is not cleared and must be written before it is solved.
module weighted_assignment_solver_core import wasa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wasa_req_if.sink   req_bus,
   wasa_rsp_if.source rsp_bus,
   wasa_csr_if.sink   csr_bus
);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_MIN_RD   = 15'b000000000000010,
      ST_MIN_EV   = 15'b000000000000100,
      ST_ROUND    = 15'b000000000001000,
      ST_TOP      = 15'b000000000010000,
      ST_SCAN     = 15'b000000000100000,
      ST_TEST     = 15'b000000001000000,
      ST_AUG      = 15'b000000010000000,
      ST_SLK_SCAN = 15'b000000100000000,
      ST_SLK_EV   = 15'b000001000000000,
      ST_ADJUST   = 15'b000010000000000,
      ST_TOT_SCAN = 15'b000100000000000,
      ST_TOT_EV   = 15'b001000000000000,
      ST_DIV      = 15'b010000000000000,
      ST_OUT      = 15'b100000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        rows_cfg_ff, rows_cfg_in;
   logic [CFG_W-1:0]        cols_cfg_ff, cols_cfg_in;
   logic [CNT_W-1:0]        nr_ff, nr_in;
   logic [CNT_W-1:0]        nc_ff, nc_in;
   logic [ROW_W-1:0]        root_ff, root_in;
   logic [ROW_W-1:0]        j_ff, j_in;
   logic [COL_W-1:0]        k_ff, k_in;
   logic [ROW_W-1:0]        r_ff, r_in;
   logic [CNT_W-1:0]        c_ff, c_in;
   logic [CNT_W-1:0]        sp_ff, sp_in;
   logic [ROW_W-1:0]        aug_ff, aug_in;
   logic [RND_W-1:0]        rounds_ff, rounds_in;
   logic [MAX_ROWS-1:0]     rv_ff, rv_in;
   logic [MAX_COLS-1:0]     cv_ff, cv_in;
   logic signed [POT_W-1:0] rp_ff [MAX_ROWS];
   logic signed [POT_W-1:0] rp_in [MAX_ROWS];
   logic signed [POT_W-1:0] cp_ff [MAX_COLS];
   logic signed [POT_W-1:0] cp_in [MAX_COLS];
   logic [OWN_W-1:0]        owner_ff [MAX_COLS];
   logic [OWN_W-1:0]        owner_in [MAX_COLS];
   logic [ROW_W-1:0]        stk_row_ff [MAX_ROWS];
   logic [ROW_W-1:0]        stk_row_in [MAX_ROWS];
   logic [CNT_W-1:0]        stk_next_ff [MAX_ROWS];
   logic [CNT_W-1:0]        stk_next_in [MAX_ROWS];
   logic [COL_W-1:0]        stk_pend_ff [MAX_ROWS];
   logic [COL_W-1:0]        stk_pend_in [MAX_ROWS];
   logic [COST_BITS-1:0]    m_ff, m_in;
   logic signed [SLK_W-1:0] d_ff, d_in;
   logic                    have_ff, have_in;
   logic [TOT_W-1:0]        total_ff, total_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [ADDR_W-1:0]       rd_addr;
   logic [COST_BITS-1:0]    rd_data;
   logic [ROW_W-1:0]        pr_idx;
   logic [COL_W-1:0]        pc_idx;
   logic signed [SLK_W-1:0] slack;
   logic [ROW_W-1:0]        t_idx;
   logic                    k_last;
   logic                    j_last;
   logic                    root_last;
   logic [COST_BITS-1:0]    m_new;
   logic [ROW_W-1:0]        own_row;
   logic [ROW_W-1:0]        tot_row;
   logic                    row_done;
   logic                    slk_adv;
   logic                    tot_adv;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // Cost memory: written from the entry channel, read by the sequencer.
   wasa_ram #(
      .WIDTH (COST_BITS),
      .DEPTH (DEPTH)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr ({ROW_W'(req_bus.row_index), COL_W'(req_bus.col_index)}),
      .wr_data (COST_BITS'(req_bus.entry_cost)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Divider for the mean cost.
   wasa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Position helpers shared by the sweeps.
   assign t_idx     = ROW_W'(sp_ff - CNT_W'(1));
   assign k_last    = (CNT_W'(k_ff) + CNT_W'(1)) == nc_ff;
   assign j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == nr_ff;
   assign root_last = (CNT_W'(root_ff) + CNT_W'(1)) == nr_ff;
   assign tot_row   = ROW_W'(owner_ff[k_ff] - OWN_W'(1));

   // Memory read address chosen by the current step.
   always_comb begin
      case (state_ff)
         ST_SCAN:     rd_addr = {r_ff, c_ff[COL_W-1:0]};
         ST_TOT_SCAN: rd_addr = {tot_row, k_ff};
         default:     rd_addr = {j_ff, k_ff};
      endcase
   end

   // Reduced cost of the edge just read from memory.
   assign pr_idx = (state_ff == ST_TEST) ? r_ff : j_ff;
   assign pc_idx = (state_ff == ST_TEST) ? c_ff[COL_W-1:0] : k_ff;
   assign slack  = $signed({{(SLK_W - COST_BITS){1'b0}}, rd_data})
                   - SLK_W'(rp_ff[pr_idx]) - SLK_W'(cp_ff[pc_idx]);
   assign m_new  = ((k_ff == '0) || (rd_data < m_ff)) ? rd_data : m_ff;
   assign own_row = ROW_W'(owner_ff[c_ff[COL_W-1:0]] - OWN_W'(1));

   // Sequencer: row minima, tight-edge search, label update, total, mean and results.
   always_comb begin
      state_in    = state_ff;
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      nr_in       = nr_ff;
      nc_in       = nc_ff;
      root_in     = root_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      sp_in       = sp_ff;
      aug_in      = aug_ff;
      rounds_in   = rounds_ff;
      rv_in       = rv_ff;
      cv_in       = cv_ff;
      rp_in       = rp_ff;
      cp_in       = cp_ff;
      owner_in    = owner_ff;
      stk_row_in  = stk_row_ff;
      stk_next_in = stk_next_ff;
      stk_pend_in = stk_pend_ff;
      m_in        = m_ff;
      d_in        = d_ff;
      have_in     = have_ff;
      total_in    = total_ff;
      row_done    = 1'b0;
      slk_adv     = 1'b0;
      tot_adv     = 1'b0;
      div_req.start    = 1'b0;
      div_req.divisor  = nr_ff;

      // Register writes.
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_NUM_ROWS: rows_cfg_in = csr_bus.data;
            REG_NUM_COLS: cols_cfg_in = csr_bus.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.last_entry) begin
               nr_in = clamp_count(rows_cfg_ff, CNT_W'(MAX_ROWS));
               nc_in = clamp_count(cols_cfg_ff, CNT_W'(MAX_COLS));
               for (int i = 0; i < MAX_COLS; i++) begin
                  owner_in[i] = '0;
                  cp_in[i]    = '0;
               end
               j_in     = '0;
               k_in     = '0;
               state_in = ST_MIN_RD;
            end
         end
         ST_MIN_RD: begin
            state_in = ST_MIN_EV;
         end
         ST_MIN_EV: begin
            m_in     = m_new;
            state_in = ST_MIN_RD;
            if (k_last) begin
               rp_in[j_ff] = $signed({{(POT_W - COST_BITS){1'b0}}, m_new});
               k_in        = '0;
               if (j_last) begin
                  root_in   = '0;
                  rounds_in = '0;
                  state_in  = ST_ROUND;
               end else begin
                  j_in = j_ff + ROW_W'(1);
               end
            end else begin
               k_in = k_ff + COL_W'(1);
            end
         end
         ST_ROUND: begin
            rv_in          = '0;
            rv_in[root_ff] = 1'b1;
            cv_in          = '0;
            sp_in          = CNT_W'(1);
            stk_row_in[0]  = root_ff;
            stk_next_in[0] = '0;
            state_in       = ST_TOP;
         end
         ST_TOP: begin
            if (sp_ff == '0) begin
               j_in     = '0;
               k_in     = '0;
               have_in  = 1'b0;
               state_in = ST_SLK_SCAN;
            end else begin
               r_in     = stk_row_ff[t_idx];
               c_in     = stk_next_ff[t_idx];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (c_ff >= nc_ff) begin
               sp_in    = sp_ff - CNT_W'(1);
               state_in = ST_TOP;
            end else if (cv_ff[c_ff[COL_W-1:0]]) begin
               c_in = c_ff + CNT_W'(1);
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (slack == '0) begin
               cv_in[c_ff[COL_W-1:0]] = 1'b1;
               if (owner_ff[c_ff[COL_W-1:0]] == '0) begin
                  // Free column: claim it and flip the path below.
                  owner_in[c_ff[COL_W-1:0]] = OWN_W'(r_ff) + OWN_W'(1);
                  aug_in   = t_idx;
                  state_in = ST_AUG;
               end else begin
                  stk_next_in[t_idx] = c_ff + CNT_W'(1);
                  stk_pend_in[t_idx] = c_ff[COL_W-1:0];
                  if (sp_ff < CNT_W'(MAX_ROWS)) begin
                     // Descend into the row that owns this column.
                     stk_row_in[sp_ff[ROW_W-1:0]]  = own_row;
                     stk_next_in[sp_ff[ROW_W-1:0]] = '0;
                     rv_in[own_row] = 1'b1;
                     sp_in    = sp_ff + CNT_W'(1);
                     state_in = ST_TOP;
                  end else begin
                     c_in     = c_ff + CNT_W'(1);
                     state_in = ST_SCAN;
                  end
               end
            end else begin
               c_in     = c_ff + CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_AUG: begin
            if (aug_ff == '0) begin
               row_done = 1'b1;
            end else begin
               owner_in[stk_pend_ff[aug_ff - ROW_W'(1)]] =
                  OWN_W'(stk_row_ff[aug_ff - ROW_W'(1)]) + OWN_W'(1);
               aug_in = aug_ff - ROW_W'(1);
            end
         end
         ST_SLK_SCAN: begin
            if (rv_ff[j_ff] && !cv_ff[k_ff]) begin
               state_in = ST_SLK_EV;
            end else begin
               slk_adv = 1'b1;
            end
         end
         ST_SLK_EV: begin
            if (!have_ff || (slack < d_ff)) begin
               d_in    = slack;
               have_in = 1'b1;
            end
            slk_adv = 1'b1;
         end
         ST_ADJUST: begin
            if (!have_ff) begin
               row_done = 1'b1;
            end else begin
               for (int i = 0; i < MAX_ROWS; i++) begin
                  if (rv_ff[i]) begin
                     rp_in[i] = POT_W'(SLK_W'(rp_ff[i]) + d_ff);
                  end
               end
               for (int i = 0; i < MAX_COLS; i++) begin
                  if (cv_ff[i]) begin
                     cp_in[i] = POT_W'(SLK_W'(cp_ff[i]) - d_ff);
                  end
               end
               if (rounds_ff == RND_W'(ROUND_LIMIT)) begin
                  row_done = 1'b1;
               end else begin
                  rounds_in = rounds_ff + RND_W'(1);
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_TOT_SCAN: begin
            if (owner_ff[k_ff] != '0) begin
               state_in = ST_TOT_EV;
            end else begin
               tot_adv = 1'b1;
            end
         end
         ST_TOT_EV: begin
            total_in = total_ff + TOT_W'(rd_data);
            tot_adv  = 1'b1;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               k_in     = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Step through the visited rows and unvisited columns for the least slack.
      if (slk_adv) begin
         state_in = ST_SLK_SCAN;
         if (k_last) begin
            k_in = '0;
            if (j_last) begin
               state_in = ST_ADJUST;
            end else begin
               j_in = j_ff + ROW_W'(1);
            end
         end else begin
            k_in = k_ff + COL_W'(1);
         end
      end

      // Next root row, or on to the total once every row has been tried.
      if (row_done) begin
         if (root_last) begin
            k_in     = '0;
            total_in = '0;
            state_in = ST_TOT_SCAN;
         end else begin
            root_in   = root_ff + ROW_W'(1);
            rounds_in = '0;
            state_in  = ST_ROUND;
         end
      end

      // Sum over the matched columns, then start the division.
      if (tot_adv) begin
         if (k_last) begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end else begin
            k_in     = k_ff + COL_W'(1);
            state_in = ST_TOT_SCAN;
         end
      end

      div_req.dividend = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rows_cfg_ff <= CFG_W'(MAX_ROWS);
         cols_cfg_ff <= CFG_W'(MAX_COLS);
      end else begin
         state_ff    <= state_in;
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
      end
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      root_ff     <= root_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      sp_ff       <= sp_in;
      aug_ff      <= aug_in;
      rounds_ff   <= rounds_in;
      rv_ff       <= rv_in;
      cv_ff       <= cv_in;
      rp_ff       <= rp_in;
      cp_ff       <= cp_in;
      owner_ff    <= owner_in;
      stk_row_ff  <= stk_row_in;
      stk_next_ff <= stk_next_in;
      stk_pend_ff <= stk_pend_in;
      m_ff        <= m_in;
      d_ff        <= d_in;
      have_ff     <= have_in;
      total_ff    <= total_in;
   end

   // Channel handshakes and result payload.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = (state_ff == ST_OUT);
   assign rsp_bus.column       = IDX_W'(k_ff);
   assign rsp_bus.matched      = (owner_ff[k_ff] != '0);
   assign rsp_bus.assigned_row = rsp_bus.matched ? IDX_W'(owner_ff[k_ff] - OWN_W'(1)) : '0;
   assign rsp_bus.total_cost   = total_ff;
   assign rsp_bus.mean_cost    = div_rsp.quotient;
   assign rsp_bus.last_result  = k_last;

endmodule

// ----- src/wasa_checker.sv -----
// Port-level checks of the solver, bound to the top level.
`timescale 1ns / 1ps
module wasa_checker import wasa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_column,
   input logic             rsp_last
);

   // Entries are never taken while results are still being delivered.
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("entry channel ready while results are pending");

   // A stalled result holds its column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column))
      else $error("stalled result changed");

   // Results of one solve follow in column order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_column == IDX_W'($past(rsp_column) + 1'b1)))
      else $error("result sequence broken");

   // After the final result the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not idle after the final result");

endmodule

bind weighted_assignment_solver_core wasa_checker u_wasa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_column (rsp_bus.column),
   .rsp_last   (rsp_bus.last_result)
);
